FILE: rtl/core/ft12_pkg.sv
package ft12_pkg;

    // Frame delimiters.
    localparam logic [7:0] START_FIXED = 8'h10;
    localparam logic [7:0] START_VAR   = 8'h68;
    localparam logic [7:0] END_CHAR    = 8'h16;

    // Saturation point of the byte position counter.
    localparam logic [8:0] POS_MAX = 9'd511;

    // Error classes reported with a verdict.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_START  = 3'd1;
    localparam logic [2:0] ERR_LEN_MATCH  = 3'd2;
    localparam logic [2:0] ERR_SEC_START  = 3'd3;
    localparam logic [2:0] ERR_END_CHAR   = 3'd4;
    localparam logic [2:0] ERR_CHECKSUM   = 3'd5;
    localparam logic [2:0] ERR_ADDRESS    = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_ADDR_LEN = 1'b0;
    localparam logic CFG_STATION  = 1'b1;

    // Address length setting that selects a two-byte link address.
    localparam logic [1:0] ADDR_LEN_TWO = 2'd2;

    // One verdict for one frame.
    typedef struct packed {
        logic        frame_ok;
        logic [2:0]  error_kind;
        logic        variable_frame;
        logic [7:0]  control_field;
        logic [15:0] link_address;
    } t_result;

endpackage

FILE: rtl/core/ft12_frame_checker.sv
// FT1.2 frame checker, receive side.
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte) and a
// flag (i_first_byte) that marks the first byte of a new buffer. A transaction
// completes on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry at most one verdict per frame: frame_ok,
// error_kind, variable_frame, control_field and link_address.
// Configuration: i_cfg_we writes i_cfg_data into the register selected by
// i_cfg_idx (0 address length, 1 station address); write only while idle.
// Path: a byte that decides a frame enters the input register when accepted,
// is decoded there, and its verdict goes into the result register, which drives the output.
// Throughput: one byte per cycle while the result register is empty or not stalled, set by
// the single decode step between the input register and the result register.
// When the receiver stalls, the verdict holds in the result register and the
// byte in the input register waits for it; once that register is full as well,
// o_stall stays high until the verdict is taken.
// Reset (synchronous, active low) empties both registers, sets the address
// length to one byte and the station address to 1, and waits for a start flag.
module ft12_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_ok,
    output logic [2:0]  o_error_kind,
    output logic        o_variable_frame,
    output logic [7:0]  o_control_field,
    output logic [15:0] o_link_address,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ft12_pkg::*;

    logic [1:0]  r_addr_len;
    logic [15:0] r_station;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic        r_out_vld;
    t_result     r_out;

    logic        in_take;
    logic        go;
    logic        res_vld;
    t_result     res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_len <= 2'd1;
            r_station  <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADDR_LEN: r_addr_len <= i_cfg_data[1:0];
                CFG_STATION:  r_station  <= i_cfg_data;
                default:      r_station  <= r_station;
            endcase
        end
    end

    // The byte in the input register is decoded when the result register can take a verdict.
    assign go      = r_in_vld && !(r_out_vld && i_stall);
    assign o_stall = r_in_vld && !go;
    assign in_take = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_rx_byte;
            r_in_first <= i_first_byte;
        end
    end

    ft12_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_byte     (r_in_byte),
        .i_first    (r_in_first),
        .i_wide_cfg (r_addr_len == ADDR_LEN_TWO),
        .i_station  (r_station),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_frame_ok       = r_out.frame_ok;
    assign o_error_kind     = r_out.error_kind;
    assign o_variable_frame = r_out.variable_frame;
    assign o_control_field  = r_out.control_field;
    assign o_link_address   = r_out.link_address;

`ifndef SYNTHESIS
    // A verdict is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> !res_vld)
        else $error("pending verdict overwritten");

    // A blocked byte stays in the input register.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !go) |=> (r_in_vld && $stable(r_in_byte) && $stable(r_in_first)))
        else $error("blocked byte lost from the input register");

    // The ok flag agrees with the error class.
    a_ok_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_ok == (o_error_kind == ERR_NONE)))
        else $error("frame_ok disagrees with error_kind");

    // Only a full input register can hold off the sender.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && r_out_vld && i_stall))
        else $error("input stalled without cause");
`endif

endmodule

FILE: rtl/core/ft12_engine.sv
module ft12_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    input  logic              i_wide_cfg,
    input  logic [15:0]       i_station,
    output logic              o_res_vld,
    output ft12_pkg::t_result o_res
);
    import ft12_pkg::*;

    logic [8:0]  r_pos;
    logic [7:0]  r_sum;
    logic [7:0]  r_len;
    logic        r_kind;
    logic [7:0]  r_ctrl;
    logic [15:0] r_addr;
    logic        r_hunt;
    logic        r_wide;
    logic        r_sum_bad;

    logic [8:0]  n_pos;
    logic [7:0]  n_sum;
    logic [7:0]  n_len;
    logic        n_kind;
    logic [7:0]  n_ctrl;
    logic [15:0] n_addr;
    logic        n_hunt;
    logic        n_wide;
    logic        n_sum_bad;

    logic [8:0]  e_pos;
    logic [7:0]  e_sum;
    logic [7:0]  e_len;
    logic        e_kind;
    logic [7:0]  e_ctrl;
    logic [15:0] e_addr;
    logic        e_hunt;
    logic        e_sum_bad;
    logic [8:0]  cs_pos;
    logic [8:0]  user_end;
    logic [7:0]  sum_add;
    logic        give;
    logic [2:0]  err;

    // A start flag clears the frame state before the byte is looked at.
    always_comb begin
        e_pos     = i_first ? 9'd0  : r_pos;
        e_sum     = i_first ? 8'd0  : r_sum;
        e_len     = i_first ? 8'd0  : r_len;
        e_kind    = i_first ? 1'b0  : r_kind;
        e_ctrl    = i_first ? 8'd0  : r_ctrl;
        e_addr    = i_first ? 16'd0 : r_addr;
        e_hunt    = i_first ? 1'b0  : r_hunt;
        e_sum_bad = i_first ? 1'b0  : r_sum_bad;
    end

    assign cs_pos   = r_wide ? 9'd4 : 9'd3;
    assign user_end = {1'b0, e_len} + 9'd3;
    assign sum_add  = e_sum + i_byte;

    // Frame decoder: one byte per call, verdict as soon as it is decided.
    always_comb begin
        n_pos     = e_pos;
        n_sum     = e_sum;
        n_len     = e_len;
        n_kind    = e_kind;
        n_ctrl    = e_ctrl;
        n_addr    = e_addr;
        n_hunt    = e_hunt;
        n_wide    = r_wide;
        n_sum_bad = e_sum_bad;
        give      = 1'b0;
        err       = ERR_NONE;

        if (!e_hunt) begin
            if (e_pos != POS_MAX) begin
                n_pos = e_pos + 9'd1;
            end

            if (e_pos == 9'd0) begin
                // Start byte: latch the address width and the frame kind.
                n_wide = i_wide_cfg;
                if (i_byte == START_FIXED) begin
                    n_kind = 1'b0;
                end else if (i_byte == START_VAR) begin
                    n_kind = 1'b1;
                end else begin
                    n_kind = 1'b0;
                    give   = 1'b1;
                    err    = ERR_BAD_START;
                end
            end else if (!e_kind) begin
                // Fixed-length frame.
                if (e_pos == 9'd1) begin
                    n_ctrl = i_byte;
                end else if (e_pos == 9'd2) begin
                    n_addr = {8'd0, i_byte};
                end else if (e_pos == 9'd3 && r_wide) begin
                    n_addr = {i_byte, e_addr[7:0]};
                end
                if (e_pos < cs_pos) begin
                    n_sum = sum_add;
                end else if (e_pos == cs_pos) begin
                    n_sum_bad = (i_byte != e_sum);
                end else begin
                    give = 1'b1;
                    if (i_byte != END_CHAR) begin
                        err = ERR_END_CHAR;
                    end else if (e_addr != i_station) begin
                        err = ERR_ADDRESS;
                    end else if (e_sum_bad) begin
                        err = ERR_CHECKSUM;
                    end
                end
            end else begin
                // Variable-length frame.
                if (e_pos == 9'd1) begin
                    n_len = i_byte;
                end else if (e_pos == 9'd2) begin
                    if (i_byte != e_len) begin
                        give = 1'b1;
                        err  = ERR_LEN_MATCH;
                    end
                end else if (e_pos == 9'd3) begin
                    if (i_byte != START_VAR) begin
                        give = 1'b1;
                        err  = ERR_SEC_START;
                    end
                end else if (e_pos <= user_end) begin
                    n_sum = sum_add;
                    if (e_pos == 9'd4) begin
                        n_ctrl = i_byte;
                    end else if (e_pos == 9'd5) begin
                        n_addr = {8'd0, i_byte};
                    end else if (e_pos == 9'd6 && r_wide) begin
                        n_addr = {i_byte, e_addr[7:0]};
                    end
                end else if (e_pos == user_end + 9'd1) begin
                    n_sum_bad = (i_byte != e_sum);
                end else begin
                    give = 1'b1;
                    if (i_byte != END_CHAR) begin
                        err = ERR_END_CHAR;
                    end else if (e_sum_bad) begin
                        err = ERR_CHECKSUM;
                    end else if (e_addr != i_station) begin
                        err = ERR_ADDRESS;
                    end
                end
            end

            if (give) begin
                n_hunt = 1'b1;
            end
        end
    end

    // Verdict fields come from the state as updated by this byte.
    assign o_res_vld            = i_go && give;
    assign o_res.frame_ok       = (err == ERR_NONE);
    assign o_res.error_kind     = err;
    assign o_res.variable_frame = n_kind;
    assign o_res.control_field  = n_ctrl;
    assign o_res.link_address   = n_addr;

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 9'd0;
            r_sum     <= 8'd0;
            r_len     <= 8'd0;
            r_kind    <= 1'b0;
            r_ctrl    <= 8'd0;
            r_addr    <= 16'd0;
            r_hunt    <= 1'b1;
            r_wide    <= 1'b0;
            r_sum_bad <= 1'b0;
        end else if (i_go) begin
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_len     <= n_len;
            r_kind    <= n_kind;
            r_ctrl    <= n_ctrl;
            r_addr    <= n_addr;
            r_hunt    <= n_hunt;
            r_wide    <= n_wide;
            r_sum_bad <= n_sum_bad;
        end
    end

`ifndef SYNTHESIS
    // A verdict always ends the frame.
    a_verdict_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |=> r_hunt)
        else $error("frame still open after a verdict");

    // While hunting, a byte without a start flag gives no verdict.
    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hunt && !i_first) |-> !give)
        else $error("verdict while waiting for a start flag");

    // A byte processed while hunting without a start flag leaves the position alone.
    a_hunt_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && r_hunt && !i_first) |=> $stable(r_pos))
        else $error("position moved while hunting");
`endif

endmodule

FILE: verif/tb_ft12_frame_checker.sv
`timescale 1ns / 1ps

module tb_ft12_frame_checker;
    import ft12_pkg::*;

    localparam int HALF_PERIOD_NS = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int PHASE_ITEMS    = 170;
    localparam int HOLD_CYCLES    = 120;
    localparam int TIMEOUT_NS     = 2000000;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [7:0] rx;
        logic       first;
        logic       typed;
        t_result    verdict;
    } t_stim_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte    = 8'h00;
    logic        i_first_byte = 1'b0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic        o_frame_ok;
    logic [2:0]  o_error_kind;
    logic        o_variable_frame;
    logic [7:0]  o_control_field;
    logic [15:0] o_link_address;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_idx    = CFG_ADDR_LEN;
    logic [15:0] i_cfg_data   = 16'h0000;

    // Tag of the directed row on the input port, -1 for random traffic.
    int row_tag = -1;

    // Idling and receiver hold-off control.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_token  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    // Shadow of the configuration registers.
    logic [1:0]  cfg_addr_len = 2'd1;
    logic [15:0] cfg_station  = 16'd1;

    // Frame decoder state of the predictor.
    logic [8:0]  pr_pos;
    logic [7:0]  pr_sum;
    logic [7:0]  pr_len;
    logic        pr_var;
    logic [7:0]  pr_ctl;
    logic [15:0] pr_addr;
    logic        pr_done;
    logic        pr_wide;
    logic        pr_sum_bad;

    t_result     verdict_q[$];
    t_stim_row   stim_rows[$];
    logic [7:0]  frame_bytes[$];
    int          depth_before;
    int          mismatch_count = 0;

    ft12_frame_checker u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_first_byte     (i_first_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_ok       (o_frame_ok),
        .o_error_kind     (o_error_kind),
        .o_variable_frame (o_variable_frame),
        .o_control_field  (o_control_field),
        .o_link_address   (o_link_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    // Records the verdict for the current frame and stops decoding until the next start.
    task automatic post_verdict(input logic [2:0] err);
        t_result v;
        v.frame_ok       = (err == ERR_NONE);
        v.error_kind     = err;
        v.variable_frame = pr_var;
        v.control_field  = pr_ctl;
        v.link_address   = pr_addr;
        verdict_q.push_back(v);
        pr_done = 1'b1;
    endtask

    // Advances the frame decoder by one accepted byte.
    task automatic predict_byte(input logic [7:0] b, input logic first);
        logic [8:0] p;
        logic [8:0] cs_pos;
        if (first) begin
            pr_pos     = '0;
            pr_sum     = '0;
            pr_len     = '0;
            pr_var     = 1'b0;
            pr_ctl     = '0;
            pr_addr    = '0;
            pr_done    = 1'b0;
            pr_sum_bad = 1'b0;
        end
        if (pr_done)
            return;
        p = pr_pos;
        if (pr_pos < POS_MAX)
            pr_pos = pr_pos + 9'd1;

        if (p == 9'd0) begin
            // Start byte: pick the frame type and latch the address width.
            pr_wide = (cfg_addr_len == ADDR_LEN_TWO);
            pr_var  = (b == START_VAR);
            if (b != START_FIXED && b != START_VAR)
                post_verdict(ERR_BAD_START);
        end else if (!pr_var) begin
            // Fixed frame: control, address, sum, end character.
            cs_pos = pr_wide ? 9'd4 : 9'd3;
            if (p == 9'd1)
                pr_ctl = b;
            else if (p == 9'd2)
                pr_addr = {8'h00, b};
            else if (p == 9'd3 && pr_wide)
                pr_addr[15:8] = b;
            if (p < cs_pos)
                pr_sum = pr_sum + b;
            else if (p == cs_pos)
                pr_sum_bad = (b != pr_sum);
            else if (b != END_CHAR)
                post_verdict(ERR_END_CHAR);
            else if (pr_addr != cfg_station)
                post_verdict(ERR_ADDRESS);
            else if (pr_sum_bad)
                post_verdict(ERR_CHECKSUM);
            else
                post_verdict(ERR_NONE);
        end else begin
            // Variable frame: header, user bytes, sum, end character.
            if (p == 9'd1) begin
                pr_len = b;
            end else if (p == 9'd2) begin
                if (b != pr_len)
                    post_verdict(ERR_LEN_MATCH);
            end else if (p == 9'd3) begin
                if (b != START_VAR)
                    post_verdict(ERR_SEC_START);
            end else if (p <= 9'd3 + pr_len) begin
                pr_sum = pr_sum + b;
                if (p == 9'd4)
                    pr_ctl = b;
                else if (p == 9'd5)
                    pr_addr = {8'h00, b};
                else if (p == 9'd6 && pr_wide)
                    pr_addr[15:8] = b;
            end else if (p == 9'd4 + pr_len) begin
                pr_sum_bad = (b != pr_sum);
            end else if (b != END_CHAR) begin
                post_verdict(ERR_END_CHAR);
            end else if (pr_sum_bad) begin
                post_verdict(ERR_CHECKSUM);
            end else if (pr_addr != cfg_station) begin
                post_verdict(ERR_ADDRESS);
            end else begin
                post_verdict(ERR_NONE);
            end
        end
    endtask

    // Monitor: tracks configuration, predicts accepted bytes, checks accepted verdicts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_addr_len = 2'd1;
            cfg_station  = 16'd1;
            pr_pos       = '0;
            pr_sum       = '0;
            pr_len       = '0;
            pr_var       = 1'b0;
            pr_ctl       = '0;
            pr_addr      = '0;
            pr_done      = 1'b1;
            pr_wide      = 1'b0;
            pr_sum_bad   = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ADDR_LEN)
                    cfg_addr_len = i_cfg_data[1:0];
                else
                    cfg_station = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                depth_before = verdict_q.size();
                predict_byte(i_rx_byte, i_first_byte);
                // Directed rows may carry a verdict written out by hand.
                if (row_tag >= 0 && verdict_q.size() > depth_before) begin
                    if (stim_rows[row_tag].typed)
                        verdict_q[verdict_q.size() - 1] = stim_rows[row_tag].verdict;
                end
            end
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected verdict transaction: error_kind %0d", o_error_kind);
                    mismatch_count++;
                end else begin
                    if (o_frame_ok !== verdict_q[0].frame_ok) begin
                        $error("frame_ok: expected %0d, got %0d",
                               verdict_q[0].frame_ok, o_frame_ok);
                        mismatch_count++;
                    end
                    if (o_error_kind !== verdict_q[0].error_kind) begin
                        $error("error_kind: expected %0d, got %0d",
                               verdict_q[0].error_kind, o_error_kind);
                        mismatch_count++;
                    end
                    if (o_variable_frame !== verdict_q[0].variable_frame) begin
                        $error("variable_frame: expected %0d, got %0d",
                               verdict_q[0].variable_frame, o_variable_frame);
                        mismatch_count++;
                    end
                    if (o_control_field !== verdict_q[0].control_field) begin
                        $error("control_field: expected 0x%02h, got 0x%02h",
                               verdict_q[0].control_field, o_control_field);
                        mismatch_count++;
                    end
                    if (o_link_address !== verdict_q[0].link_address) begin
                        $error("link_address: expected 0x%04h, got 0x%04h",
                               verdict_q[0].link_address, o_link_address);
                        mismatch_count++;
                    end
                    verdict_q.pop_front();
                end
            end
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                tx_idle_pct <= 18;
                rx_idle_pct <= 53;
            end
            1: begin
                tx_idle_pct <= 53;
                rx_idle_pct <= 18;
            end
            default: begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
        endcase
    endtask

    // Offers one byte, with random idle cycles ahead of it, and waits for the transaction.
    task automatic send_byte(input logic [7:0] b, input logic first, input int tag);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_rx_byte    <= b;
        i_first_byte <= first;
        row_tag      <= tag;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Waits until no verdict has been pending for the given number of cycles.
    task automatic wait_quiet(input int cycles);
        int quiet;
        quiet = 0;
        while (quiet < cycles) begin
            @(posedge i_clk);
            if (verdict_q.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // Writes the address length register, then the station register; the block is idle here.
    task automatic write_config(input logic [1:0] addr_len, input logic [15:0] station);
        logic [15:0] junk;
        junk       = 16'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ADDR_LEN;
        i_cfg_data <= {junk[15:2], addr_len};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STATION;
        i_cfg_data <= station;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic add_row(input logic [7:0] rx, input logic first, input logic typed,
                           input t_result verdict);
        t_stim_row row;
        row.rx      = rx;
        row.first   = first;
        row.typed   = typed;
        row.verdict = verdict;
        stim_rows.push_back(row);
    endtask

    // Builds one random frame, well formed or damaged, or a run of noise bytes, and sends it.
    task automatic send_random_frame(inout int count);
        int          pick;
        int          fault;
        int          n;
        int          i;
        logic        wide;
        logic [7:0]  ctl;
        logic [7:0]  len;
        logic [7:0]  len2;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] addr;
        wide  = (cfg_addr_len == ADDR_LEN_TWO);
        ctl   = 8'($urandom);
        addr  = ($urandom_range(3) != 0) ? cfg_station : 16'($urandom);
        fault = $urandom_range(11);
        pick  = $urandom_range(99);
        frame_bytes.delete();
        if (pick < 40) begin
            // Fixed frame.
            sum = ctl + addr[7:0] + (wide ? addr[15:8] : 8'h00);
            frame_bytes.push_back(START_FIXED);
            frame_bytes.push_back(ctl);
            frame_bytes.push_back(addr[7:0]);
            if (wide)
                frame_bytes.push_back(addr[15:8]);
            frame_bytes.push_back((fault == 1) ? sum + 8'h01 : sum);
            frame_bytes.push_back((fault == 0) ? 8'($urandom) : END_CHAR);
        end else if (pick < 82) begin
            // Variable frame; mostly short user data, now and then a long one.
            n = $urandom_range(99);
            if (n < 85)
                len = 8'($urandom_range(8));
            else if (n < 97)
                len = 8'($urandom_range(40, 9));
            else
                len = 8'($urandom_range(255, 41));
            len2 = (fault == 2) ? len ^ (8'h01 << $urandom_range(7)) : len;
            frame_bytes.push_back(START_VAR);
            frame_bytes.push_back(len);
            frame_bytes.push_back(len2);
            frame_bytes.push_back((fault == 3) ? 8'($urandom) : START_VAR);
            sum = 8'h00;
            for (i = 0; i < len; i++) begin
                if (i == 0)
                    b = ctl;
                else if (i == 1)
                    b = addr[7:0];
                else if (i == 2 && wide)
                    b = addr[15:8];
                else
                    b = 8'($urandom);
                frame_bytes.push_back(b);
                sum = sum + b;
            end
            frame_bytes.push_back((fault == 1) ? ~sum : sum);
            frame_bytes.push_back((fault == 0) ? 8'($urandom) : END_CHAR);
        end else if (pick < 92) begin
            // Noise with scattered start flags.
            n = $urandom_range(6, 1);
            for (i = 0; i < n; i++) begin
                send_byte(8'($urandom), (i == 0) || ($urandom_range(3) == 0), -1);
                count++;
            end
            return;
        end else begin
            // Arbitrary start byte followed by up to two more bytes.
            n = $urandom_range(3, 1);
            for (i = 0; i < n; i++)
                frame_bytes.push_back(8'($urandom));
        end
        // Cut the frame short, or let junk trail behind it.
        if (fault == 4 && frame_bytes.size() > 1) begin
            n = $urandom_range(frame_bytes.size() - 1, 1);
            while (frame_bytes.size() > n)
                void'(frame_bytes.pop_back());
        end else if (fault == 5) begin
            n = $urandom_range(3, 1);
            for (i = 0; i < n; i++)
                frame_bytes.push_back(8'($urandom));
        end
        for (i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == 0, -1);
            count++;
        end
    endtask

    // Main sequence: reset, directed table, then random phases over several settings.
    initial begin
        logic [1:0]  len_tab[6];
        logic [15:0] station_tab[6];
        int          ph;
        int          r;
        int          sent;
        logic        held;
        logic        paused;

        len_tab[0] = 2'd1;  station_tab[0] = 16'd1;
        len_tab[1] = 2'd2;  station_tab[1] = 16'hFFFF;
        len_tab[2] = 2'd0;  station_tab[2] = 16'h0000;
        len_tab[3] = 2'd3;  station_tab[3] = 16'($urandom_range(255));
        len_tab[4] = 2'd2;  station_tab[4] = 16'($urandom);
        len_tab[5] = 2'd1;  station_tab[5] = 16'($urandom);

        // Byte ahead of any start flag is ignored.
        add_row(8'h55, 1'b0, 1'b0, '0);
        // Non-start byte with the start flag.
        add_row(8'h00, 1'b1, 1'b1, '{1'b0, ERR_BAD_START, 1'b0, 8'h00, 16'h0000});
        // Good fixed frame at the reset settings, then an ignored trailing byte.
        add_row(START_FIXED, 1'b1, 1'b0, '0);
        add_row(8'h53, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h54, 1'b0, 1'b0, '0);
        add_row(END_CHAR, 1'b0, 1'b1, '{1'b1, ERR_NONE, 1'b0, 8'h53, 16'h0001});
        add_row(END_CHAR, 1'b0, 1'b0, '0);
        // Length copies disagree.
        add_row(START_VAR, 1'b1, 1'b0, '0);
        add_row(8'h05, 1'b0, 1'b0, '0);
        add_row(8'h06, 1'b0, 1'b1, '{1'b0, ERR_LEN_MATCH, 1'b1, 8'h00, 16'h0000});
        // Wrong second start character.
        add_row(START_VAR, 1'b1, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, '0);
        add_row(START_FIXED, 1'b0, 1'b1, '{1'b0, ERR_SEC_START, 1'b1, 8'h00, 16'h0000});
        // Unfinished frame dropped by a new start.
        add_row(START_FIXED, 1'b1, 1'b0, '0);
        add_row(8'hAA, 1'b0, 1'b0, '0);
        // Variable frame with no user data: address reads as zero.
        add_row(START_VAR, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(START_VAR, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(END_CHAR, 1'b0, 1'b1, '{1'b0, ERR_ADDRESS, 1'b1, 8'h00, 16'h0000});
        // All-ones fixed frame, wrong address.
        add_row(START_FIXED, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFE, 1'b0, 1'b0, '0);
        add_row(END_CHAR, 1'b0, 1'b1, '{1'b0, ERR_ADDRESS, 1'b0, 8'hFF, 16'h00FF});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);
        @(posedge i_clk);

        for (r = 0; r < stim_rows.size(); r++)
            send_byte(stim_rows[r].rx, stim_rows[r].first, r);
        i_valid <= 1'b0;

        held   = 1'b0;
        paused = 1'b0;
        for (ph = 0; ph < 6; ph++) begin
            wait_quiet(4);
            write_config(len_tab[ph], station_tab[ph]);
            set_idling(ph / 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_random_frame(sent);
                // Long receiver hold-off while the sender keeps going.
                if (ph == 4 && !held && sent > 40) begin
                    hold_token <= hold_token + 1;
                    held = 1'b1;
                end
                // Sender pause until every pending verdict has come out.
                if (ph == 5 && !paused && sent > 80) begin
                    i_valid <= 1'b0;
                    wait_quiet(1);
                    paused = 1'b1;
                end
            end
            i_valid <= 1'b0;
        end

        wait_quiet(8);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ft12_pkg.sv
rtl/core/ft12_engine.sv
rtl/core/ft12_frame_checker.sv
verif/tb_ft12_frame_checker.sv
